/* design/ascending_integer_sorter_assert.svh */
`ifndef ASCENDING_INTEGER_SORTER_ASSERT_SVH
`define ASCENDING_INTEGER_SORTER_ASSERT_SVH

// same-cycle implication
`define AIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ais_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ais_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* design/ais_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ais_cell
	import ais_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire data_t      new_value,
	input  wire logic       prev_valid,
	input  wire logic       prev_greater,
	input  wire data_t      prev_value,
	input  wire logic       next_valid,
	input  wire data_t      next_value,
	output logic            valid,
	output data_t           value,
	output logic            greater
);

	logic  valid_q;
	data_t value_q;

	assign valid   = valid_q;
	assign value   = value_q;
	assign greater = valid_q && (value_q > new_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.insert && (!valid_q || greater)) begin
			if (prev_greater) begin
				value_q <= prev_value;
			end else if (prev_valid) begin
				value_q <= new_value;
			end
		end
	end

endmodule
`default_nettype wire

/* design/ascending_integer_sorter.sv */
// The first result is registered at the output after the tlast word moves the state to drain.
// Throughput: one input word per cycle while collecting, then one result per
// cycle while draining and m_tready is high; no input is taken while a set drains.
// Words beyond CAPACITY are dropped and the set's results carry overflow.
// Reset clears the cell valid bits, the count, the drop flag and the state.
`timescale 1ns / 1ps
`default_nettype none
`include "ascending_integer_sorter_assert.svh"
module ascending_integer_sorter
	import ais_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic signed [31:0] s_tdata,  // value
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic signed [31:0]     m_tdata,   // sorted_value
	output logic                   m_tlast,
	output logic                   m_tuser    // overflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q;
	logic           dropped_q;
	logic           m_tvalid_q;
	data_t          m_tdata_q;
	logic           m_tlast_q;
	logic           m_tuser_q;

	logic           in_fire;
	logic           full;
	logic           out_load;
	cell_ctrl_t     ctrl;

	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_greater;
	data_t               cell_value [CAPACITY];

	assign full     = (count_q == CW'(CAPACITY));
	assign s_tready = (state_q == ST_COLLECT);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DRAIN) && (!m_tvalid_q || m_tready);

	assign ctrl.insert = in_fire && !full;
	assign ctrl.shift  = out_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (in_fire && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_load && (count_q == CW'(1))) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (in_fire) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (out_load) begin
			count_q <= count_q - CW'(1);
			if (count_q == CW'(1)) begin
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= cell_value[0];
			m_tlast_q <= (count_q == CW'(1));
			m_tuser_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  prev_valid;
		logic  prev_greater;
		data_t prev_value;
		logic  next_valid;
		data_t next_value;

		if (i == 0) begin : g_head
			assign prev_valid   = 1'b1;
			assign prev_greater = 1'b0;
			assign prev_value   = '0;
		end else begin : g_body
			assign prev_valid   = cell_valid[i-1];
			assign prev_greater = cell_greater[i-1];
			assign prev_value   = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_value = '0;
		end else begin : g_link
			assign next_valid = cell_valid[i+1];
			assign next_value = cell_value[i+1];
		end

		ais_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (s_tdata),
			.prev_valid  (prev_valid),
			.prev_greater(prev_greater),
			.prev_value  (prev_value),
			.next_valid  (next_valid),
			.next_value  (next_value),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.greater     (cell_greater[i])
		);

		if (i < CAPACITY - 1) begin : g_chk
			`AIS_ASSERT_NOW(a_cells_ordered, cell_valid[i+1], cell_value[i] <= cell_value[i+1], "cells out of order")
		end
	end

	`AIS_ASSERT_NOW(a_count_matches_cells, 1'b1, CW'($countones(cell_valid)) == count_q, "count does not match occupied cells")
	`AIS_ASSERT_NOW(a_cells_packed, 1'b1, ((cell_valid + CAPACITY'(1)) & cell_valid) == '0, "occupied cells not packed")
	`AIS_ASSERT_NOW(a_drop_only_when_full, $rose(dropped_q), count_q == CW'(CAPACITY), "word dropped below capacity")
	`AIS_ASSERT_NEXT(a_drain_after_last, in_fire && s_tlast, state_q == ST_DRAIN && count_q != '0, "set closed without results")

endmodule
`default_nettype wire

/* bench/ascending_integer_sorter_test.sv */
`timescale 1ns / 1ps
module ascending_integer_sorter_test;
	import ais_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		data_t value;
		logic  last;
	} word_t;

	typedef struct packed {
		data_t value;
		logic  last;
		logic  overflow;
	} result_t;

	logic  clk;
	logic  arst_n;
	logic  s_tvalid;
	logic  s_tready;
	data_t s_tdata;
	logic  s_tlast;
	logic  m_tvalid;
	logic  m_tready;
	data_t m_tdata;
	logic  m_tlast;
	logic  m_tuser;

	word_t   pending_words[$];
	result_t sorted_due[$];
	data_t   set_values[$];
	logic    set_dropped;
	logic    in_taken;
	int      words_left;
	int      errors;
	int      cycle_count;
	int      tx_idle_pct;
	int      rx_idle_pct;

	data_t burst [17] = '{3, -3, 3, 32'h7fff_ffff, 32'h8000_0000, 0, -1, 1, 3, 100, -100,
		32'h4000_0000, 32'hc000_0000, 7, 7, -7, 42};

	ascending_integer_sorter #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic flag_error(input string what);
		errors++;
		$display("%0t: %s", $realtime, what);
	endtask

	// store the word, and on tlast emit the set in ascending order
	task automatic take_word(input data_t value, input logic last);
		data_t   ordered[$];
		data_t   hold;
		int      j;
		result_t res;
		if (set_values.size() < CAPACITY)
			set_values.push_back(value);
		else
			set_dropped = 1'b1;
		if (last) begin
			ordered = set_values;
			for (int i = 1; i < ordered.size(); i++) begin
				hold = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > hold) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = hold;
			end
			for (int i = 0; i < ordered.size(); i++) begin
				res.value = ordered[i];
				res.last = (i == ordered.size() - 1);
				res.overflow = set_dropped;
				sorted_due.push_back(res);
			end
			set_values.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic queue_word(input data_t value, input logic last);
		word_t w;
		w.value = value;
		w.last = last;
		pending_words.push_back(w);
		words_left++;
	endtask

	function automatic data_t pick_value(input int style);
		data_t v;
		case (style)
			0: v = data_t'($urandom_range(16)) - 8;
			1: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 0;
					default: v = 32'hffff_ffff;
				endcase
			end
			default: v = data_t'($urandom());
		endcase
		return v;
	endfunction

	task automatic queue_sets(input int n_words);
		int queued;
		int len;
		int style;
		int sel;
		queued = 0;
		while (queued < n_words) begin
			sel = $urandom_range(99);
			if (sel < 8)
				len = 1;
			else if (sel < 20)
				len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
			else
				len = $urandom_range(CAPACITY, 2);
			style = $urandom_range(3);
			for (int i = 0; i < len; i++)
				queue_word(pick_value($urandom_range(2) == 0 ? 2 : style), i == len - 1);
			queued += len;
		end
	endtask

	task automatic drain;
		while (words_left != 0 || sorted_due.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		word_t next_word;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_word.value;
					s_tlast <= next_word.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (sorted_due.size() == 0) begin
					flag_error($sformatf("unexpected word %0d", m_tdata));
				end else begin
					want = sorted_due.pop_front();
					if (m_tdata !== want.value)
						flag_error($sformatf("value %0d, want %0d", m_tdata, want.value));
					if (m_tlast !== want.last)
						flag_error($sformatf("tlast %b, want %b", m_tlast, want.last));
					if (m_tuser !== want.overflow)
						flag_error($sformatf("overflow %b, want %b", m_tuser, want.overflow));
				end
			end
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				take_word(s_tdata, s_tlast);
				words_left--;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ascending_integer_sorter_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		in_taken = 1'b0;
		set_dropped = 1'b0;
		words_left = 0;
		errors = 0;
		cycle_count = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 85;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-word set
		queue_word(32'h8000_0000, 1'b1);
		// signed ordering across extremes
		queue_word(32'h7fff_ffff, 1'b0);
		queue_word(32'h8000_0000, 1'b0);
		queue_word(0, 1'b0);
		queue_word(-1, 1'b0);
		queue_word(1, 1'b1);
		// full store, tlast word dropped
		for (int i = 0; i < 17; i++)
			queue_word(burst[i], i == 16);
		queue_sets(90);
		drain();

		tx_idle_pct = 85;
		rx_idle_pct = 15;
		queue_sets(90);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_sets(90);
		drain();

		repeat (20) @(posedge clk);
		if (sorted_due.size() != 0)
			flag_error($sformatf("%0d results never arrived", sorted_due.size()));
		if (errors == 0)
			$display("ascending_integer_sorter_test: clean");
		else
			$display("ascending_integer_sorter_test: errors");
		$finish;
	end

endmodule
